### design/fld_pkg.sv
// Shared types and constants for the frame length deframer.
// Used by fld_parser and frame_length_deframer; no dependencies.
package fld_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 28;
  localparam int unsigned TOTAL_W = 29;
  localparam int unsigned CNT_W   = 3;

  localparam logic [BYTE_W-1:0] LEN_DIGIT_MASK = 8'h7f;
  localparam logic [BYTE_W-1:0] LEN_MORE_BIT   = 8'h80;

  // Byte role codes reported with every result
  typedef enum logic [1:0] {
    ROLE_TYPE    = 2'd0,
    ROLE_LENGTH  = 2'd1,
    ROLE_PAYLOAD = 2'd2,
    ROLE_DISCARD = 2'd3
  } role_t;

  typedef enum logic [3:0] {
    PH_TYPE    = 4'b0001,
    PH_LEN     = 4'b0010,
    PH_PAY     = 4'b0100,
    PH_DISCARD = 4'b1000
  } phase_t;

  typedef struct packed {
    role_t                byte_role;
    logic [BYTE_W-1:0]    message_type;
    logic [LEN_W-1:0]     decoded_len;
    logic                 frame_end;
    logic [TOTAL_W-1:0]   frame_total_length;
    logic                 protocol_error;
  } result_t;

endpackage

### design/fld_parser.sv
// Frame parser: phase state, type latch, base-128 length decode, payload count.
// Depends on fld_pkg. Produces one result per stepped byte, combinationally.
module fld_parser #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [fld_pkg::BYTE_W-1:0] rx_byte,
  input  logic                    resync,
  output fld_pkg::result_t        res
);
  import fld_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LENGTH_BYTES);

  phase_t              phase_r, phase_nxt, phase_eff;
  logic [BYTE_W-1:0]   type_r, type_nxt;
  logic [LEN_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LEN_W-1:0]    left_r, left_nxt;
  logic [LEN_W-1:0]    digit_sh;
  logic [LEN_W-1:0]    acc_add;
  logic [CNT_W-1:0]    cnt_inc;
  logic [LEN_W-1:0]    left_dec;
  logic [BYTE_W-1:0]   digit;

  assign phase_eff = resync ? PH_TYPE : phase_r;
  assign digit     = rx_byte & LEN_DIGIT_MASK;
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign acc_add   = acc_r + digit_sh;
  assign left_dec  = left_r - LEN_W'(1);

  // 7 bits further up per length byte
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    digit_sh = LEN_W'(digit);
      2'd1:    digit_sh = LEN_W'(digit) << 7;
      2'd2:    digit_sh = LEN_W'(digit) << 14;
      default: digit_sh = LEN_W'(digit) << 21;
    endcase
  end

  always_comb begin
    phase_nxt = phase_eff;
    type_nxt  = type_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    res.byte_role          = ROLE_DISCARD;
    res.frame_end          = 1'b0;
    res.frame_total_length = '0;
    res.protocol_error     = 1'b0;
    unique case (phase_eff)
      PH_TYPE: begin
        type_nxt      = rx_byte;
        acc_nxt       = '0;
        cnt_nxt       = '0;
        left_nxt      = '0;
        phase_nxt     = PH_LEN;
        res.byte_role = ROLE_TYPE;
      end
      PH_LEN: begin
        acc_nxt       = acc_add;
        cnt_nxt       = cnt_inc;
        res.byte_role = ROLE_LENGTH;
        if ((rx_byte & LEN_MORE_BIT) != '0) begin
          if (cnt_inc >= MAX_CNT) begin
            res.protocol_error = 1'b1;
            phase_nxt          = PH_DISCARD;
          end
        end else if (acc_add == '0) begin
          res.frame_end          = 1'b1;
          res.frame_total_length = TOTAL_W'(1) + TOTAL_W'(cnt_inc);
          phase_nxt              = PH_TYPE;
        end else begin
          left_nxt  = acc_add;
          phase_nxt = PH_PAY;
        end
      end
      PH_PAY: begin
        res.byte_role = ROLE_PAYLOAD;
        left_nxt      = left_dec;
        if (left_dec == '0) begin
          res.frame_end          = 1'b1;
          res.frame_total_length = TOTAL_W'(1) + TOTAL_W'(cnt_r) + TOTAL_W'(acc_r);
          phase_nxt              = PH_TYPE;
        end
      end
      default: begin
        res.byte_role = ROLE_DISCARD;
      end
    endcase
    res.message_type = type_nxt;
    res.decoded_len  = acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      type_r  <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      left_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_to_type: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.frame_end |=> phase_r == PH_TYPE)
    else $error("frame end did not return to type phase");

  a_err_to_discard: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.protocol_error |=> phase_r == PH_DISCARD)
    else $error("length error did not enter discard");

  a_discard_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    step && !resync && phase_r == PH_DISCARD |=> phase_r == PH_DISCARD)
    else $error("left discard without resync");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("length byte count beyond limit");

  a_pay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAY |-> left_r != '0)
    else $error("payload phase with nothing left");
`endif

endmodule

### design/frame_length_deframer.sv
// Top level of the frame length deframer: input register, parser, result register.
// Depends on fld_pkg and fld_parser.
//
// Byte-stream deframer for frames made of a type byte, a little-endian base-128
// length field (7 bits per byte, bit 7 = more follows, at most MAX_LENGTH_BYTES
// bytes) and that many payload bytes. Every input transfer yields exactly one output
// transfer, tagged with its role; the byte that completes a frame asserts out_tlast
// and carries the total frame length. A continuation bit on the last allowed length
// byte flags protocol_error and discards bytes until an input with resync set. Each
// byte is held in the input register and then passes through the parser stage into
// the result register, and one byte is taken every cycle while the output side
// accepts.
module frame_length_deframer #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] resync
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] message_type, [35:8] decoded_len,
                                  // [64:36] frame_total_length, [71:65] zero
  output logic [2:0]  out_tuser,  // [1:0] byte_role, [2] protocol_error
  output logic        out_tlast   // frame_end
);
  import fld_pkg::*;

  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_resync_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r;
  result_t           res;
  logic              advance;
  logic              in_xfer;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  fld_parser #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .resync  (in_resync_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_byte_r   <= '0;
      in_resync_r <= 1'b0;
    end else if (in_xfer) begin
      in_byte_r   <= in_tdata;
      in_resync_r <= in_tuser[0];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.frame_total_length, out_res_r.decoded_len,
                       out_res_r.message_type};
  assign out_tuser  = {out_res_r.protocol_error, out_res_r.byte_role};
  assign out_tlast  = out_res_r.frame_end;

endmodule
